FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: design/ddrq_pkg.sv
// ----------------------------------------------------------------------------
// ddrq_pkg
// Types, function codes and default sizes of the dirty-region queue.
// ----------------------------------------------------------------------------
package ddrq_pkg;

  localparam int FUNC_W  = 3;
  localparam int COORD_W = 32;
  localparam int CNT_W   = 7;

  localparam int QUEUE_DEPTH_DEF   = 64;
  localparam int REGION_SIZE_X_DEF = 16;
  localparam int REGION_SIZE_Y_DEF = 16;
  localparam int REGION_SIZE_Z_DEF = 16;

  localparam logic [FUNC_W-1:0] FN_MARK_DIRTY  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_MARK_URGENT = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POLL_NORMAL = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POLL_URGENT = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR       = 3'd4;

  typedef struct packed {
    logic        [FUNC_W-1:0]  func;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic                      newly_queued;
    logic                      overflow;
    logic                      found;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic        [CNT_W-1:0]   normal_count;
    logic        [CNT_W-1:0]   urgent_count;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } key_t;

endpackage

FILE: design/ddrq_ram.sv
// ----------------------------------------------------------------------------
// ddrq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ddrq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/dedup_dirty_region_queue_unit.sv
// ----------------------------------------------------------------------------
// dedup_dirty_region_queue_unit
// Two duplicate-free stores of region coordinates: a normal FIFO fed by
// block marks (shifted down to region coordinates) and an urgent LIFO.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_ready   | in_data  (in_item_t)
//   out     | output    | out_valid / out_ready | out_data (out_item_t)
//
// A mark searches its store for a duplicate before in_ready returns; a
// duplicate found early ends the search. The search uses the one shared
// comparator, reading one stored entry per cycle from that store's RAM.
// A poll that finds an entry waits for its RAM read before the result;
// an empty poll, clear and a spare function code go straight to the result.
// Reset (rst_n low, synchronous) empties both stores; no clearing pass.
// The result register holds while out_ready is low; the next item is taken
// meanwhile and its result waits in the final state.
// ----------------------------------------------------------------------------
module dedup_dirty_region_queue_unit #(
  parameter int QUEUE_DEPTH   = ddrq_pkg::QUEUE_DEPTH_DEF,
  parameter int REGION_SIZE_X = ddrq_pkg::REGION_SIZE_X_DEF,
  parameter int REGION_SIZE_Y = ddrq_pkg::REGION_SIZE_Y_DEF,
  parameter int REGION_SIZE_Z = ddrq_pkg::REGION_SIZE_Z_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ddrq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ddrq_pkg::out_item_t out_data
);

  import ddrq_pkg::*;

  localparam int AW  = $clog2(QUEUE_DEPTH);
  localparam int FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SHX = $clog2(REGION_SIZE_X + 1) - 1;
  localparam int SHY = $clog2(REGION_SIZE_Y + 1) - 1;
  localparam int SHZ = $clog2(REGION_SIZE_Z + 1) - 1;
  localparam logic [FW-1:0] FILL_FULL = FW'(QUEUE_DEPTH);
  localparam logic [FW-1:0] FILL_ONE  = FW'(1);
  localparam logic [AW-1:0] ADDR_ONE  = AW'(1);
  localparam logic [AW-1:0] ADDR_LAST = AW'(QUEUE_DEPTH - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SRCH = 2'd1;
  localparam logic [1:0] ST_RDWT = 2'd2;
  localparam logic [1:0] ST_RESP = 2'd3;

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [FW-1:0] ofs);
    logic [AW+1:0] sum;
    sum = (AW+2)'(base) + (AW+2)'(ofs);
    if (sum >= (AW+2)'(QUEUE_DEPTH)) begin
      sum = sum - (AW+2)'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  logic [1:0]        state_r, state_nxt;
  logic [FUNC_W-1:0] func_r, func_nxt;
  key_t              key_r, key_nxt;
  logic [FW-1:0]     idx_r, idx_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic              dup_r, dup_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [FW-1:0]     nfill_r, nfill_nxt;
  logic [FW-1:0]     ufill_r, ufill_nxt;
  out_item_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              n_wr_en, u_wr_en, n_rd_en, u_rd_en;
  logic [AW-1:0]     n_wr_addr, n_rd_addr, u_rd_addr;
  logic [FW-1:0]     utop;
  key_t              n_rd_data, u_rd_data, cmp_data, in_key;
  logic              is_urg, match;
  logic [FW-1:0]     sel_fill;

  assign is_urg   = (func_r == FN_MARK_URGENT) || (func_r == FN_POLL_URGENT);
  assign cmp_data = is_urg ? u_rd_data : n_rd_data;
  assign match    = (cmp_data == key_r);
  assign sel_fill = is_urg ? ufill_r : nfill_r;
  assign utop     = ufill_r - FILL_ONE;

  assign n_rd_addr = (state_r == ST_IDLE) ? head_r : wrap_add(head_r, idx_r);
  assign u_rd_addr = (state_r == ST_IDLE) ? utop[AW-1:0] : idx_r[AW-1:0];
  assign n_wr_addr = wrap_add(head_r, nfill_r);

  always_comb begin
    if (in_data.func == FN_MARK_DIRTY) begin
      in_key.x = in_data.coord_x >>> SHX;
      in_key.y = in_data.coord_y >>> SHY;
      in_key.z = in_data.coord_z >>> SHZ;
    end else begin
      in_key.x = in_data.coord_x;
      in_key.y = in_data.coord_y;
      in_key.z = in_data.coord_z;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    key_nxt       = key_r;
    idx_nxt       = idx_r;
    cmp_vld_nxt   = cmp_vld_r;
    dup_nxt       = dup_r;
    head_nxt      = head_r;
    nfill_nxt     = nfill_r;
    ufill_nxt     = ufill_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    n_wr_en       = 1'b0;
    u_wr_en       = 1'b0;
    n_rd_en       = 1'b0;
    u_rd_en       = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          func_nxt    = in_data.func;
          key_nxt     = in_key;
          idx_nxt     = '0;
          cmp_vld_nxt = 1'b0;
          dup_nxt     = 1'b0;
          priority if (in_data.func == FN_MARK_DIRTY ||
                       in_data.func == FN_MARK_URGENT) begin
            state_nxt = ST_SRCH;
          end else if (in_data.func == FN_POLL_NORMAL && nfill_r != '0) begin
            n_rd_en   = 1'b1;
            state_nxt = ST_RDWT;
          end else if (in_data.func == FN_POLL_URGENT && ufill_r != '0) begin
            u_rd_en   = 1'b1;
            state_nxt = ST_RDWT;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_SRCH: begin
        priority if (cmp_vld_r && match) begin
          dup_nxt     = 1'b1;
          cmp_vld_nxt = 1'b0;
          state_nxt   = ST_RESP;
        end else if (idx_r == sel_fill) begin
          cmp_vld_nxt = 1'b0;
          state_nxt   = ST_RESP;
        end else begin
          n_rd_en     = !is_urg;
          u_rd_en     = is_urg;
          idx_nxt     = idx_r + FILL_ONE;
          cmp_vld_nxt = 1'b1;
        end
      end
      ST_RDWT: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_nxt = '0;
          unique case (func_r)
            FN_MARK_DIRTY: begin
              if (!dup_r) begin
                if (nfill_r == FILL_FULL) begin
                  out_nxt.overflow = 1'b1;
                end else begin
                  n_wr_en              = 1'b1;
                  nfill_nxt            = nfill_r + FILL_ONE;
                  out_nxt.newly_queued = 1'b1;
                end
              end
            end
            FN_MARK_URGENT: begin
              if (!dup_r) begin
                if (ufill_r == FILL_FULL) begin
                  out_nxt.overflow = 1'b1;
                end else begin
                  u_wr_en              = 1'b1;
                  ufill_nxt            = ufill_r + FILL_ONE;
                  out_nxt.newly_queued = 1'b1;
                end
              end
            end
            FN_POLL_NORMAL: begin
              if (nfill_r != '0) begin
                out_nxt.found = 1'b1;
                out_nxt.out_x = n_rd_data.x;
                out_nxt.out_y = n_rd_data.y;
                out_nxt.out_z = n_rd_data.z;
                head_nxt      = (head_r == ADDR_LAST) ? '0 : head_r + ADDR_ONE;
                nfill_nxt     = nfill_r - FILL_ONE;
              end
            end
            FN_POLL_URGENT: begin
              if (ufill_r != '0) begin
                out_nxt.found = 1'b1;
                out_nxt.out_x = u_rd_data.x;
                out_nxt.out_y = u_rd_data.y;
                out_nxt.out_z = u_rd_data.z;
                ufill_nxt     = utop;
              end
            end
            FN_CLEAR: begin
              head_nxt  = '0;
              nfill_nxt = '0;
              ufill_nxt = '0;
            end
            default: begin
            end
          endcase
          out_nxt.normal_count = CNT_W'(nfill_nxt);
          out_nxt.urgent_count = CNT_W'(ufill_nxt);
          out_valid_nxt        = 1'b1;
          state_nxt            = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cmp_vld_r   <= 1'b0;
      head_r      <= '0;
      nfill_r     <= '0;
      ufill_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      head_r      <= head_nxt;
      nfill_r     <= nfill_nxt;
      ufill_r     <= ufill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    key_r  <= key_nxt;
    idx_r  <= idx_nxt;
    dup_r  <= dup_nxt;
    out_r  <= out_nxt;
  end

  ddrq_ram #(
    .WIDTH ($bits(key_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_normal_ram (
    .clk     (clk),
    .wr_en   (n_wr_en),
    .wr_addr (n_wr_addr),
    .wr_data (key_r),
    .rd_en   (n_rd_en),
    .rd_addr (n_rd_addr),
    .rd_data (n_rd_data)
  );

  ddrq_ram #(
    .WIDTH ($bits(key_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_urgent_ram (
    .clk     (clk),
    .wr_en   (u_wr_en),
    .wr_addr (ufill_r[AW-1:0]),
    .wr_data (key_r),
    .rd_en   (u_rd_en),
    .rd_addr (u_rd_addr),
    .rd_data (u_rd_data)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: design/ddrq_checker.sv
// ----------------------------------------------------------------------------
// ddrq_checker
// Port-level checks of the dirty-region queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ddrq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input ddrq_pkg::out_item_t out_data
);

  `ASSERT_IMPLIES(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed before transfer")

  `ASSERT_IMPLIES(a_busy_after_take, clk, rst_n, in_valid && in_ready |=> !in_ready, "input taken while an item is at work")

  `ASSERT_NEVER(a_flags_excl, clk, rst_n, out_valid && (out_data.found && (out_data.newly_queued || out_data.overflow) || out_data.newly_queued && out_data.overflow), "conflicting result flags")

  `ASSERT_NEVER(a_empty_poll_zero, clk, rst_n, out_valid && !out_data.found && (out_data.out_x != 0 || out_data.out_y != 0 || out_data.out_z != 0), "coordinates without a found entry")

endmodule

bind dedup_dirty_region_queue_unit ddrq_checker u_ddrq_checker (.*);
